// ----- design/tfmd_pkg.sv -----
// Shared types and constants for the truncating float multiply/divide pipeline.
package tfmd_pkg;
    localparam int FRAC_W = 23;
    localparam int EXP_W = 8;
    localparam int SIG_W = FRAC_W + 1;
    localparam int PROD_W = 2 * SIG_W;
    localparam int RECIP_STEPS = 2 * FRAC_W + 1;
    localparam int BIAS = 127;
    localparam int EXP_MAX = 255;

    typedef enum logic {
        KIND_MUL = 1'b0,
        KIND_DIV = 1'b1
    } kind_t;

    // Per-item payload carried beside the reciprocal divider.
    typedef struct packed {
        logic               sign;
        logic [EXP_W-1:0]   ea;
        logic [FRAC_W-1:0]  fa;
        logic [EXP_W-1:0]   eb;
        logic [FRAC_W-1:0]  fb;
        logic               a_zero;
        logic               div_nz;
    } op_t;
endpackage

// ----- design/tfmd_recip.sv -----
// Pipelined restoring divider: one quotient bit of 2^(2F+1)/m per stage.
module tfmd_recip (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              adv,
    input  logic                              in_valid,
    input  tfmd_pkg::op_t                     in_op,
    output logic                              out_valid,
    output tfmd_pkg::op_t                     out_op,
    output logic [tfmd_pkg::FRAC_W-1:0]       out_q
);
    import tfmd_pkg::*;

    localparam int STG = RECIP_STEPS;

    logic [SIG_W:0]  rem_reg  [STG+1];
    logic [FRAC_W:0] quo_reg  [STG+1];
    op_t             op_reg   [STG+1];
    logic            vld_reg  [STG+1];

    // Stage 0 register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
        end
        if (adv) begin
            rem_reg[0] <= (SIG_W+1)'(1);
            quo_reg[0] <= '0;
            op_reg[0]  <= in_op;
        end
    end

    // One shift-compare-subtract per stage
    for (genvar i = 0; i < STG; i++) begin : g_step
        logic [SIG_W:0] sh;
        logic [SIG_W:0] m;
        logic           ge;
        assign sh = {rem_reg[i][SIG_W-1:0], 1'b0};
        assign m  = {2'b01, op_reg[i].fb};
        assign ge = (sh >= m);
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            if (adv) begin
                rem_reg[i+1] <= ge ? sh - m : sh;
                quo_reg[i+1] <= {quo_reg[i][FRAC_W-1:0], ge};
                op_reg[i+1]  <= op_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[STG];
    assign out_op    = op_reg[STG];
    assign out_q     = quo_reg[STG][FRAC_W-1:0];
endmodule

// ----- design/tfmd_mul.sv -----
// Significand multiply, normalize and exponent clamp, three register stages.
module tfmd_mul (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   adv,
    input  logic                   in_valid,
    input  tfmd_pkg::op_t          in_op,
    input  logic [tfmd_pkg::FRAC_W-1:0] in_q,
    output logic                   out_valid,
    output logic [31:0]            out_bits
);
    import tfmd_pkg::*;

    logic                v1_reg, v2_reg, v3_reg;
    logic                s1_reg, s2_reg;
    logic                z1_reg, z2_reg;
    logic [EXP_W-1:0]    ea1_reg, eb1_reg;
    logic [SIG_W-1:0]    ma1_reg, mb1_reg;
    logic [PROD_W-1:0]   p2_reg;
    logic [EXP_W:0]      es2_reg;
    logic [31:0]         r3_reg;

    // Stage 1: resolve divisor reciprocal and zero tests
    logic [FRAC_W-1:0] fb_c;
    logic [EXP_W-1:0]  eb_c;
    logic              bz_c;
    always_comb begin
        fb_c = in_op.div_nz ? in_q : in_op.fb;
        eb_c = in_op.eb;
        bz_c = (eb_c == '0) && (fb_c == '0);
    end

    // Stage 2: multiply and exponent sum
    logic [PROD_W-1:0] prod_c;
    assign prod_c = PROD_W'(ma1_reg) * PROD_W'(mb1_reg);

    // Stage 3: normalize, clamp, pack
    logic              norm_c;
    logic [FRAC_W-1:0] fr_c;
    logic signed [EXP_W+2:0] e_c;
    logic [EXP_W-1:0]  ex_c;
    always_comb begin
        norm_c = p2_reg[PROD_W-1];
        fr_c = norm_c ? p2_reg[PROD_W-2 -: FRAC_W] : p2_reg[PROD_W-3 -: FRAC_W];
        e_c = $signed({2'b00, es2_reg}) - (EXP_W+3)'(BIAS) + (EXP_W+3)'(norm_c);
        if (e_c > $signed((EXP_W+3)'(EXP_MAX))) begin
            ex_c = EXP_W'(EXP_MAX);
        end else if (e_c < 0) begin
            ex_c = '0;
        end else begin
            ex_c = e_c[EXP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        if (adv) begin
            s1_reg  <= in_op.sign;
            z1_reg  <= in_op.a_zero | bz_c;
            ea1_reg <= in_op.ea;
            eb1_reg <= eb_c;
            ma1_reg <= {1'b1, in_op.fa};
            mb1_reg <= {1'b1, fb_c};
            s2_reg  <= s1_reg;
            z2_reg  <= z1_reg;
            p2_reg  <= prod_c;
            es2_reg <= (EXP_W+1)'(ea1_reg) + (EXP_W+1)'(eb1_reg);
            r3_reg  <= z2_reg ? {s2_reg, 31'b0} : {s2_reg, ex_c, fr_c};
        end
    end

    assign out_valid = v3_reg;
    assign out_bits  = r3_reg;
endmodule

// ----- design/truncating_float_mul_div_top.sv -----
// Top level: truncating single-precision multiply/divide stream pipeline.
// Path from input accept to result valid: 1 operand decode register,
// 47 reciprocal divider stages, 3 multiply stages; multiplies take the same path.
// Throughput: one item per cycle; the whole pipe holds on output backpressure.
// Reset: synchronous active-low aresetn clears all valid bits.
module truncating_float_mul_div_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [0] kind, [32:1] a_bits, [64:33] b_bits, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] result_bits
);
    import tfmd_pkg::*;

    logic        adv;
    logic        rv;
    op_t         dec_c, rop;
    logic [FRAC_W-1:0] rq;
    logic [31:0] a, b;
    logic [EXP_W-1:0] eb_raw;
    logic [FRAC_W-1:0] fb_raw;
    logic        div;
    logic signed [EXP_W+1:0] er;

    // Pipe advances unless the output holds an untaken item
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Decode operands; compute reciprocal exponent
    always_comb begin
        div    = (kind_t'(s_tdata[0]) == KIND_DIV);
        a      = s_tdata[32:1];
        b      = s_tdata[64:33];
        eb_raw = b[30:23];
        fb_raw = b[22:0];
        er     = (EXP_W+2)'(2*BIAS) - $signed({2'b00, eb_raw})
               - (EXP_W+2)'(fb_raw != '0);
        dec_c.sign   = a[31] ^ b[31];
        dec_c.ea     = a[30:23];
        dec_c.fa     = a[22:0];
        dec_c.fb     = fb_raw;
        dec_c.a_zero = (a[30:0] == '0);
        dec_c.div_nz = div && (fb_raw != '0);
        if (!div) begin
            dec_c.eb = eb_raw;
        end else if (b[30:0] == '0) begin
            dec_c.eb = EXP_W'(EXP_MAX);
        end else if (er < 0) begin
            dec_c.eb = '0;
        end else begin
            dec_c.eb = er[EXP_W-1:0];
        end
    end

    tfmd_recip u_recip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_op     (dec_c),
        .out_valid (rv),
        .out_op    (rop),
        .out_q     (rq)
    );

    tfmd_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (rv),
        .in_op     (rop),
        .in_q      (rq),
        .out_valid (m_tvalid),
        .out_bits  (m_tdata)
    );
endmodule

// ----- design/tfmd_checker.sv -----
// Port-level checker for the multiply/divide pipeline, bound to the top level.
module tfmd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    // Stalled result holds its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // Input is taken whenever output is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // Backpressure blocks input
    a_bp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // No result right after reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("valid after reset");
endmodule

bind truncating_float_mul_div_top tfmd_checker u_tfmd_checker (.*);

// ----- sim/testbench.sv -----
// Self-checking testbench for the truncating float multiply/divide stream pipeline.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tfmd_pkg::*;

    localparam int PIPE_LAT = 51;
    localparam int STALL_LIMIT = 4000;
    localparam int RAND_ITEMS = 1031;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] a_bits;
        logic [31:0] b_bits;
    } op_item_t;

    typedef struct {
        op_item_t    op;
        bit          typed;
        logic [31:0] result;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    logic [31:0] expected_results[$];
    stim_row_t   stim_table[$];
    int          mismatch_count;
    int          quiet_cycles;
    bit          stimulus_done;

    truncating_float_mul_div_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 12 ns clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // floor(2^(2F+1) / m) by restoring division
    function automatic logic [FRAC_W:0] recip_quotient(logic [FRAC_W:0] sig);
        logic [FRAC_W+1:0] rem;
        logic [FRAC_W:0]   quo;
        rem = 1;
        quo = 0;
        for (int i = 0; i < 2 * FRAC_W + 1; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= {1'b0, sig}) begin
                rem = rem - {1'b0, sig};
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Compute the truncated product or quotient bit pattern
    function automatic logic [31:0] mul_div_result(op_item_t op);
        logic              sgn;
        logic [7:0]        ea, eb;
        logic [FRAC_W-1:0] fa, fb;
        logic [47:0]       prod;
        logic              norm;
        int                e;
        logic [7:0]        er;
        logic [FRAC_W-1:0] fr;
        logic [FRAC_W:0]   rq;
        sgn = op.a_bits[31] ^ op.b_bits[31];
        ea = op.a_bits[30:23];
        fa = op.a_bits[22:0];
        eb = op.b_bits[30:23];
        fb = op.b_bits[22:0];
        if (op.kind == KIND_DIV) begin
            if (eb == 0 && fb == 0) begin
                eb = 8'(EXP_MAX);
            end else begin
                e = 2 * BIAS - int'(eb);
                if (fb != 0) begin
                    e = e - 1;
                    rq = recip_quotient({1'b1, fb});
                    fb = rq[FRAC_W-1:0];
                end
                if (e < 0) e = 0;
                eb = e[7:0];
            end
        end
        if ((ea == 0 && fa == 0) || (eb == 0 && fb == 0)) begin
            er = 0;
            fr = 0;
        end else begin
            prod = {24'd0, 1'b1, fa} * {24'd0, 1'b1, fb};
            norm = prod[47];
            fr = norm ? prod[46:24] : prod[45:23];
            e = int'(ea) + int'(eb) - BIAS + int'(norm);
            if (e > EXP_MAX) e = EXP_MAX;
            if (e < 0) e = 0;
            er = e[7:0];
        end
        return {sgn, er, fr};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got %08h expected %08h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [31:0] random_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0: v[30:0] = 0;
            1: v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            2: v[22:0] = 0;
            3: v[30:23] = 8'($urandom_range(100, 154));
            default: ;
        endcase
        return v;
    endfunction

    task automatic add_row(kind_t k, logic [31:0] a, logic [31:0] b,
                           bit typed, logic [31:0] r);
        stim_row_t row;
        row.op = '{kind: k, a_bits: a, b_bits: b};
        row.typed = typed;
        row.result = r;
        stim_table.push_back(row);
    endtask

    // Drive one item, holding valid through the handshake
    task automatic send_item(op_item_t op);
        s_tdata <= {7'd0, op.b_bits, op.a_bits, op.kind};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Sender: directed table, then random items in bursts
    initial begin
        int burst;
        op_item_t op;
        logic [31:0] want;
        mismatch_count = 0;
        stimulus_done = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        add_row(KIND_MUL, 32'h3F800000, 32'h3F800000, 1, 32'h3F800000);
        add_row(KIND_MUL, 32'h00000000, 32'h7FFFFFFF, 1, 32'h00000000);
        add_row(KIND_MUL, 32'h80000000, 32'h3F800000, 1, 32'h80000000);
        add_row(KIND_MUL, 32'h7F800000, 32'h7F800000, 1, 32'h7F800000);
        add_row(KIND_MUL, 32'h00800000, 32'h00800000, 1, 32'h00000000);
        add_row(KIND_MUL, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0);
        add_row(KIND_MUL, 32'h7FFFFFFF, 32'h00000001, 0, 0);
        add_row(KIND_MUL, 32'h3FFFFFFF, 32'hBFFFFFFF, 0, 0);
        add_row(KIND_DIV, 32'h3F800000, 32'h00000000, 1, 32'h7F800000);
        add_row(KIND_DIV, 32'h3F800000, 32'h80000000, 1, 32'hFF800000);
        add_row(KIND_DIV, 32'h00000000, 32'h00000000, 1, 32'h00000000);
        add_row(KIND_DIV, 32'h40000000, 32'h3F800000, 1, 32'h40000000);
        add_row(KIND_DIV, 32'h3F800000, 32'h7F800000, 0, 0);
        add_row(KIND_DIV, 32'h3F800000, 32'h7F7FFFFF, 0, 0);
        add_row(KIND_DIV, 32'h3F800000, 32'h7FFFFFFF, 0, 0);
        add_row(KIND_DIV, 32'h40400000, 32'h40400000, 0, 0);
        add_row(KIND_DIV, 32'hFFFFFFFF, 32'h00000001, 0, 0);
        add_row(KIND_DIV, 32'h3F800000, 32'h00800000, 0, 0);
        add_row(KIND_DIV, 32'h12345678, 32'h9ABCDEF0, 0, 0);

        foreach (stim_table[i]) begin
            want = mul_div_result(stim_table[i].op);
            if (stim_table[i].typed && want != stim_table[i].result)
                report_mismatch("directed table row", want, stim_table[i].result);
            expected_results.push_back(stim_table[i].typed ? stim_table[i].result : want);
            send_item(stim_table[i].op);
        end

        for (int n = 0; n < RAND_ITEMS; ) begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst && n < RAND_ITEMS; j++, n++) begin
                op.kind = kind_t'($urandom_range(0, 1));
                op.a_bits = random_float();
                op.b_bits = random_float();
                expected_results.push_back(mul_div_result(op));
                send_item(op);
            end
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b0;
        stimulus_done = 1;
    end

    // Receiver stall pattern: alternating ready and stall stretches
    initial begin
        m_tready = 1'b0;
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 60)) @(negedge aclk);
            if ($urandom_range(0, 2) != 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", m_tdata, 32'h0);
            else if (m_tdata !== expected_results[0])
                report_mismatch("result_bits", m_tdata, expected_results.pop_front());
            else
                void'(expected_results.pop_front());
        end
    end

    // Watchdog on cycles with no accepted item, and end of run
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("truncating_float_mul_div_top test failed");
                $finish;
            end
            if (stimulus_done && expected_results.size() == 0) begin
                repeat (PIPE_LAT + 10) @(posedge aclk);
                if (mismatch_count == 0 && expected_results.size() == 0) begin
                    $display("truncating_float_mul_div_top test passed");
                end else begin
                    $display("truncating_float_mul_div_top test failed");
                end
                $finish;
            end
        end
    end
endmodule

// ----- sim.f -----
design/tfmd_pkg.sv
design/tfmd_recip.sv
design/tfmd_mul.sv
design/truncating_float_mul_div_top.sv
design/tfmd_checker.sv
sim/testbench.sv
